// ----- rtl/cmw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmw_pkg: contraharmonic mean window filter shared definitions
// Widths, request and result types and the per-tap sample select.
// ----------------------------------------------------------------------------
package cmw_pkg;

  localparam int WINDOW_TAPS = 9;
  localparam int SAMPLE_BITS = 8;
  localparam int ENTRY_BITS  = 40;

  localparam int TABLE_DEPTH = 2 ** SAMPLE_BITS;
  localparam int PROD_BITS   = ENTRY_BITS + SAMPLE_BITS;
  localparam int SUM_GUARD   = 4;
  localparam int DEN_BITS    = ENTRY_BITS + SUM_GUARD;
  localparam int NUM_BITS    = PROD_BITS + SUM_GUARD;
  localparam int GROUP_TAPS  = 3;
  localparam int GROUPS      = (WINDOW_TAPS + GROUP_TAPS - 1) / GROUP_TAPS;
  localparam int DIV_STAGES  = SAMPLE_BITS;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_WINDOW = 1'b1;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic                  req_type;
    sample_t               sample_0;
    sample_t               sample_1;
    sample_t               sample_2;
    sample_t               sample_3;
    sample_t               sample_4;
    sample_t               sample_5;
    sample_t               sample_6;
    sample_t               sample_7;
    sample_t               sample_8;
    logic [7:0]            table_index;
    logic [ENTRY_BITS-1:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [7:0] filtered;
    logic       computed;
  } res_t;

  // sideband travelling alongside each request through the pipeline
  typedef struct packed {
    logic    valid;
    logic    win;
    sample_t centre;
  } ctl_t;

  function automatic sample_t sample_at(input req_t req, input int idx);
    sample_t s;
    s = '0;
    case (idx)
      0:       s = req.sample_0;
      1:       s = req.sample_1;
      2:       s = req.sample_2;
      3:       s = req.sample_3;
      4:       s = req.sample_4;
      5:       s = req.sample_5;
      6:       s = req.sample_6;
      7:       s = req.sample_7;
      8:       s = req.sample_8;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/cmw_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmw_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module cmw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cmw_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmw_lane: one window tap
// Holds a private copy of the power table, looks up the tap's weight and
// forms the masked weight and sample-weight product.
// ----------------------------------------------------------------------------
module cmw_lane (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire logic                            we_i,
  input  wire logic [cmw_pkg::SAMPLE_BITS-1:0] waddr_i,
  input  wire logic [cmw_pkg::ENTRY_BITS-1:0]  wdata_i,
  input  wire cmw_pkg::sample_t                sample_i,
  output logic      [cmw_pkg::PROD_BITS-1:0]   prod_o,
  output logic      [cmw_pkg::ENTRY_BITS-1:0]  weight_o
);

  logic [cmw_pkg::ENTRY_BITS-1:0] tbl_rdata;
  cmw_pkg::sample_t               x_q;
  logic [cmw_pkg::PROD_BITS-1:0]  prod_d;
  logic [cmw_pkg::ENTRY_BITS-1:0] weight_d;

  cmw_ram #(
    .WIDTH(cmw_pkg::ENTRY_BITS),
    .DEPTH(cmw_pkg::TABLE_DEPTH)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .re_i    (en_i),
    .raddr_i (sample_i),
    .rdata_o (tbl_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= sample_i;
    end
  end

  // zero samples take no part
  always_comb begin
    if (x_q == '0) begin
      prod_d   = '0;
      weight_d = '0;
    end else begin
      prod_d   = cmw_pkg::PROD_BITS'(x_q) * cmw_pkg::PROD_BITS'(tbl_rdata);
      weight_d = tbl_rdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_o   <= prod_d;
      weight_o <= weight_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cmw_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmw_merge: lane merge
// Two-level registered adder tree: partial sums over groups of taps, then
// the grand numerator and denominator.
// ----------------------------------------------------------------------------
module cmw_merge (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire cmw_pkg::ctl_t                  ctl_i,
  input  wire logic [cmw_pkg::PROD_BITS-1:0]  prod_i   [cmw_pkg::WINDOW_TAPS],
  input  wire logic [cmw_pkg::ENTRY_BITS-1:0] weight_i [cmw_pkg::WINDOW_TAPS],
  output cmw_pkg::ctl_t                       ctl_o,
  output logic      [cmw_pkg::NUM_BITS-1:0]   num_o,
  output logic      [cmw_pkg::DEN_BITS-1:0]   den_o
);

  logic [cmw_pkg::NUM_BITS-1:0] grp_num_d [cmw_pkg::GROUPS];
  logic [cmw_pkg::DEN_BITS-1:0] grp_den_d [cmw_pkg::GROUPS];
  logic [cmw_pkg::NUM_BITS-1:0] grp_num_q [cmw_pkg::GROUPS];
  logic [cmw_pkg::DEN_BITS-1:0] grp_den_q [cmw_pkg::GROUPS];
  logic [cmw_pkg::NUM_BITS-1:0] num_d;
  logic [cmw_pkg::DEN_BITS-1:0] den_d;
  cmw_pkg::ctl_t                ctl_q;

  always_comb begin
    int idx;
    for (int g = 0; g < cmw_pkg::GROUPS; g++) begin
      grp_num_d[g] = '0;
      grp_den_d[g] = '0;
      for (int j = 0; j < cmw_pkg::GROUP_TAPS; j++) begin
        idx = g * cmw_pkg::GROUP_TAPS + j;
        if (idx < cmw_pkg::WINDOW_TAPS) begin
          grp_num_d[g] = grp_num_d[g] + cmw_pkg::NUM_BITS'(prod_i[idx]);
          grp_den_d[g] = grp_den_d[g] + cmw_pkg::DEN_BITS'(weight_i[idx]);
        end
      end
    end
  end

  always_comb begin
    num_d = '0;
    den_d = '0;
    for (int g = 0; g < cmw_pkg::GROUPS; g++) begin
      num_d = num_d + grp_num_q[g];
      den_d = den_d + grp_den_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      grp_num_q <= grp_num_d;
      grp_den_q <= grp_den_d;
      num_o     <= num_d;
      den_o     <= den_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
      ctl_o <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
      ctl_o <= ctl_q;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cmw_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmw_div: pipelined quotient and result select
// Saturation check, then one restoring quotient bit per stage, then the
// result register choosing load zero, centre pass, clamp or quotient.
// ----------------------------------------------------------------------------
module cmw_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire cmw_pkg::ctl_t                ctl_i,
  input  wire logic [cmw_pkg::NUM_BITS-1:0] num_i,
  input  wire logic [cmw_pkg::DEN_BITS-1:0] den_i,
  output logic                              out_valid_o,
  output cmw_pkg::res_t                     out_res_o
);

  localparam int NS = cmw_pkg::DIV_STAGES + 1;

  logic [cmw_pkg::NUM_BITS-1:0]    rem_q  [NS];
  logic [cmw_pkg::DEN_BITS-1:0]    den_q  [NS];
  logic [cmw_pkg::SAMPLE_BITS-1:0] quo_q  [NS];
  logic                            sat_q  [NS];
  logic                            zero_q [NS];
  cmw_pkg::ctl_t                   ctl_q  [NS];

  logic [cmw_pkg::NUM_BITS-1:0] den_top;
  cmw_pkg::res_t                res_d;

  assign den_top = {den_i, {cmw_pkg::SAMPLE_BITS{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_i;
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      sat_q[0]  <= (num_i >= den_top);
      zero_q[0] <= (den_i == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q[0] <= '0;
    end else if (en_i) begin
      ctl_q[0] <= ctl_i;
    end
  end

  for (genvar i = 0; i < cmw_pkg::DIV_STAGES; i++) begin : g_stage
    localparam int K = cmw_pkg::DIV_STAGES - 1 - i;

    logic [cmw_pkg::NUM_BITS-1:0]    den_sh;
    logic [cmw_pkg::NUM_BITS-1:0]    rem_d;
    logic [cmw_pkg::SAMPLE_BITS-1:0] quo_d;

    assign den_sh = cmw_pkg::NUM_BITS'(den_q[i]) << K;

    always_comb begin
      rem_d = rem_q[i];
      quo_d = quo_q[i];
      if (rem_q[i] >= den_sh) begin
        rem_d    = rem_q[i] - den_sh;
        quo_d[K] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1]  <= rem_d;
        den_q[i+1]  <= den_q[i];
        quo_q[i+1]  <= quo_d;
        sat_q[i+1]  <= sat_q[i];
        zero_q[i+1] <= zero_q[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[i+1] <= '0;
      end else if (en_i) begin
        ctl_q[i+1] <= ctl_q[i];
      end
    end
  end

  always_comb begin
    res_d = '0;
    if (ctl_q[NS-1].win == cmw_pkg::REQ_WINDOW) begin
      if (zero_q[NS-1]) begin
        res_d.filtered = 8'(ctl_q[NS-1].centre);
      end else if (sat_q[NS-1]) begin
        res_d.filtered = 8'hff;
        res_d.computed = 1'b1;
      end else begin
        res_d.filtered = 8'(quo_q[NS-1]);
        res_d.computed = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_res_o <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en_i) begin
      out_valid_o <= ctl_q[NS-1].valid;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/contraharmonic_mean_window.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// contraharmonic_mean_window: 3x3 contraharmonic mean filter, one channel
// Input channel in_*: a request either loads one power table entry
// (req_type 0, table_index, entry_value) or filters a window (req_type 1,
// sample_0..sample_8). Output channel out_*: one result per request, in
// order; loads return filtered 0, computed 0.
// Nine lanes each hold a copy of the power table and form weight and
// sample-weight product; a two-level adder tree merges them; a restoring
// divider produces one quotient bit per stage.
// Throughput: one request per cycle while out_stall_i is low.
// The whole pipeline advances together: when the output register is full
// and out_stall_i is high, every stage holds and in_stall_o rises, so
// nothing is dropped or repeated. A load is visible to the next request.
// Reset clears all valid flags; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module contraharmonic_mean_window (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire cmw_pkg::req_t in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output cmw_pkg::res_t      out_res_o
);

  logic          en;
  logic          accept;
  logic          tbl_we;
  cmw_pkg::ctl_t ctl_in;
  cmw_pkg::ctl_t ctl_s1_q;
  cmw_pkg::ctl_t ctl_s2_q;
  cmw_pkg::ctl_t ctl_m;

  logic [cmw_pkg::PROD_BITS-1:0]  lane_prod   [cmw_pkg::WINDOW_TAPS];
  logic [cmw_pkg::ENTRY_BITS-1:0] lane_weight [cmw_pkg::WINDOW_TAPS];
  logic [cmw_pkg::NUM_BITS-1:0]   num_m;
  logic [cmw_pkg::DEN_BITS-1:0]   den_m;

  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;
  assign tbl_we     = accept && (in_req_i.req_type == cmw_pkg::REQ_LOAD);

  assign ctl_in.valid  = in_valid_i;
  assign ctl_in.win    = in_req_i.req_type;
  assign ctl_in.centre = in_req_i.sample_4;

  for (genvar t = 0; t < cmw_pkg::WINDOW_TAPS; t++) begin : g_lane
    cmw_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (en),
      .we_i     (tbl_we),
      .waddr_i  (in_req_i.table_index),
      .wdata_i  (in_req_i.entry_value),
      .sample_i (cmw_pkg::sample_at(in_req_i, t)),
      .prod_o   (lane_prod[t]),
      .weight_o (lane_weight[t])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_s1_q <= '0;
      ctl_s2_q <= '0;
    end else if (en) begin
      ctl_s1_q <= ctl_in;
      ctl_s2_q <= ctl_s1_q;
    end
  end

  cmw_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .ctl_i    (ctl_s2_q),
    .prod_i   (lane_prod),
    .weight_i (lane_weight),
    .ctl_o    (ctl_m),
    .num_o    (num_m),
    .den_o    (den_m)
  );

  cmw_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .ctl_i       (ctl_m),
    .num_i       (num_m),
    .den_i       (den_m),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res_o)
  );

endmodule
`default_nettype wire

// ----- test/cmw_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cmw_checker: result predictor and in-order comparator
// Keeps its own copy of the power table, fed from accepted load requests,
// works out the filtered value of every accepted request and checks each
// accepted result, field by field, against the oldest prediction.
// ---------------------------------------------------------------------------
module cmw_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  cmw_pkg::req_t  in_req_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  cmw_pkg::res_t  out_res_i,
  output int             fail_count_o,
  output int             pending_o
);

  logic [cmw_pkg::ENTRY_BITS-1:0] weight_tbl [cmw_pkg::TABLE_DEPTH];
  cmw_pkg::res_t                  expected_pixels [$];
  cmw_pkg::res_t                  want;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  function automatic cmw_pkg::res_t contraharmonic_pixel(input cmw_pkg::req_t r);
    cmw_pkg::sample_t taps [9];
    logic [63:0]      num;
    logic [63:0]      den;
    logic [63:0]      quot;
    cmw_pkg::res_t    res;
    taps = '{r.sample_0, r.sample_1, r.sample_2, r.sample_3, r.sample_4,
             r.sample_5, r.sample_6, r.sample_7, r.sample_8};
    num  = '0;
    den  = '0;
    for (int t = 0; t < cmw_pkg::WINDOW_TAPS; t++) begin
      if (taps[t] != '0) begin
        den += 64'(weight_tbl[taps[t]]);
        num += 64'(taps[t]) * 64'(weight_tbl[taps[t]]);
      end
    end
    if (den == '0) begin
      // no usable weight: centre passes through
      res.filtered = r.sample_4;
      res.computed = 1'b0;
    end else begin
      quot = num / den;
      if (quot > 64'd255) quot = 64'd255;
      res.filtered = quot[7:0];
      res.computed = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_pixels.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("result %0h with no request outstanding", out_res_i));
        end else begin
          want = expected_pixels.pop_front();
          if (out_res_i.filtered !== want.filtered)
            report_mismatch($sformatf("filtered %0d, predicted %0d",
                                      out_res_i.filtered, want.filtered));
          if (out_res_i.computed !== want.computed)
            report_mismatch($sformatf("computed %b, predicted %b",
                                      out_res_i.computed, want.computed));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_req_i.req_type == cmw_pkg::REQ_LOAD) begin
          weight_tbl[in_req_i.table_index] = in_req_i.entry_value;
          expected_pixels.push_back('0);
        end else begin
          expected_pixels.push_back(contraharmonic_pixel(in_req_i));
        end
      end
      pending_o = expected_pixels.size();
    end
  end

endmodule

// ----- test/tb_contraharmonic_mean_window.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_contraharmonic_mean_window: regression for the 3x3 contraharmonic filter
// Directed loads and windows cover the weight and sample extremes, the
// pass-through cases and load-then-use ordering; random traffic follows,
// with random idling on both channels, a long output hold-off, a full drain
// and a stretch at full rate. Windows only read table entries already loaded.
// ---------------------------------------------------------------------------
module tb_contraharmonic_mean_window;

  localparam int LATENCY     = 14;
  localparam int HOLD_CYCLES = 80;

  typedef cmw_pkg::sample_t window_t [9];

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  cmw_pkg::req_t in_req;
  logic          out_valid;
  logic          out_stall;
  cmw_pkg::res_t out_res;
  int            fails;
  int            pending;

  bit            loaded [256];
  bit            zero_weight [256];
  logic [7:0]    loaded_list [$];
  bit            src_quiet;
  bit            sink_quiet;
  bit            hold_off;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  contraharmonic_mean_window i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_res_o   (out_res)
  );

  cmw_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_res_i    (out_res),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  function automatic cmw_pkg::req_t noisy_request();
    logic [127:0]  noise;
    cmw_pkg::req_t r;
    noise = {$urandom, $urandom, $urandom, $urandom};
    r     = noise[$bits(cmw_pkg::req_t)-1:0];
    return r;
  endfunction

  function automatic logic [39:0] random_weight();
    logic [63:0] raw;
    int          pick;
    pick = $urandom_range(0, 19);
    raw  = {$urandom, $urandom};
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return raw[39:0] >> $urandom_range(0, 39);
  endfunction

  // zero, or a sample whose table entry is loaded (optionally zero-weight only)
  function automatic cmw_pkg::sample_t random_sample(input bit dead_only);
    cmw_pkg::sample_t pool [$];
    if ($urandom_range(0, 4) == 0) return '0;
    foreach (loaded_list[k])
      if (!dead_only || zero_weight[loaded_list[k]]) pool.push_back(loaded_list[k]);
    if (pool.size() == 0) return '0;
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  task automatic offer_request(input cmw_pkg::req_t r);
    while (!src_quiet && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_entry(input logic [7:0] idx, input logic [39:0] value);
    cmw_pkg::req_t r;
    r             = noisy_request();
    r.req_type    = cmw_pkg::REQ_LOAD;
    r.table_index = idx;
    r.entry_value = value;
    offer_request(r);
    if (!loaded[idx]) loaded_list.push_back(idx);
    loaded[idx]      = 1'b1;
    zero_weight[idx] = (value == '0);
  endtask

  task automatic send_window(input window_t w);
    cmw_pkg::req_t r;
    r          = noisy_request();
    r.req_type = cmw_pkg::REQ_WINDOW;
    r.sample_0 = w[0];
    r.sample_1 = w[1];
    r.sample_2 = w[2];
    r.sample_3 = w[3];
    r.sample_4 = w[4];
    r.sample_5 = w[5];
    r.sample_6 = w[6];
    r.sample_7 = w[7];
    r.sample_8 = w[8];
    offer_request(r);
  endtask

  task automatic random_window();
    window_t          w;
    int               mode;
    cmw_pkg::sample_t same;
    mode = $urandom_range(0, 99);
    same = random_sample(1'b0);
    foreach (w[k]) begin
      if (mode < 4)       w[k] = '0;
      else if (mode < 12) w[k] = random_sample(1'b1);
      else if (mode < 22) w[k] = same;
      else                w[k] = random_sample(1'b0);
    end
    send_window(w);
  endtask

  task automatic random_request();
    if ($urandom_range(0, 99) < 18) begin
      load_entry(8'($urandom), random_weight());
    end else begin
      random_window();
    end
  endtask

  task automatic wait_results_home();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // receiver side
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end else begin
        out_stall <= !sink_quiet && ($urandom_range(0, 99) < 37);
      end
    end
  end

  initial begin
    window_t w;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_req     = '0;
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
    hold_off   = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // entry 0 loaded first so a zero sample never meets an unwritten entry
    load_entry(8'd0, random_weight());
    w = '{default: 8'd0};
    send_window(w);
    load_entry(8'd255, '1);
    load_entry(8'd1, '1);
    load_entry(8'd128, '0);
    load_entry(8'd2, 40'd1);
    w = '{default: 8'd255};
    send_window(w);
    w = '{default: 8'd1};
    send_window(w);
    w = '{8'd255, 8'd1, 8'd255, 8'd1, 8'd0, 8'd1, 8'd255, 8'd1, 8'd255};
    send_window(w);
    w = '{default: 8'd128};
    send_window(w);
    w = '{8'd128, 8'd128, 8'd128, 8'd128, 8'd0, 8'd128, 8'd128, 8'd128, 8'd128};
    send_window(w);
    w = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd2};
    send_window(w);
    // reload followed at once by a use of the new weight
    src_quiet = 1'b1;
    load_entry(8'd1, 40'd1);
    w = '{8'd1, 8'd255, 8'd1, 8'd255, 8'd128, 8'd1, 8'd2, 8'd0, 8'd255};
    send_window(w);
    load_entry(8'd2, '1);
    w = '{8'd2, 8'd2, 8'd1, 8'd0, 8'd2, 8'd255, 8'd128, 8'd2, 8'd1};
    send_window(w);
    src_quiet = 1'b0;

    repeat (220) random_request();

    // long output hold-off while requests keep coming
    src_quiet = 1'b1;
    hold_off  = 1'b1;
    repeat (60) random_request();
    src_quiet = 1'b0;
    wait_results_home();

    src_quiet  = 1'b1;
    sink_quiet = 1'b1;
    repeat (150) random_request();
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;

    repeat (200) random_request();

    wait_results_home();
    repeat (LATENCY + 6) @(negedge clk);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- contraharmonic_mean_window.f -----
rtl/cmw_pkg.sv
rtl/cmw_ram.sv
rtl/cmw_lane.sv
rtl/cmw_merge.sv
rtl/cmw_div.sv
rtl/contraharmonic_mean_window.sv
test/cmw_checker.sv
test/tb_contraharmonic_mean_window.sv
